>>> src/m3h_pkg.sv
// ----------------------------------------------------------------------------
// m3h_pkg
// Shared constants, types and helper functions for the 128-bit murmur
// hash stream: mixing constants, queue entry layout and byte masking.
// ----------------------------------------------------------------------------
package m3h_pkg;

  localparam logic [63:0] MUL_K1 = 64'h87c37b91114253d5;
  localparam logic [63:0] MUL_K2 = 64'h4cf5ad432745937f;
  localparam logic [63:0] FMIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] ADD_H1 = 64'h0000000052dce729;
  localparam logic [63:0] ADD_H2 = 64'h0000000038495ab5;

  localparam logic [4:0] BLOCK_BYTES = 5'd16;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [63:0] w0;
    logic [63:0] w1;
    logic [4:0]  cnt;
    logic        last;
    logic        body;
  } blk_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

  function automatic logic [63:0] keep_bytes(input logic [63:0] v, input logic [4:0] n,
                                             input logic [4:0] base);
    logic [63:0] res;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      if ((5'(i) + base) < n) begin
        res[8*i +: 8] = v[8*i +: 8];
      end
    end
    return res;
  endfunction

  function automatic logic [63:0] xshift33(input logic [63:0] v);
    return v ^ (v >> 33);
  endfunction

endpackage

>>> src/m3h_front.sv
// ----------------------------------------------------------------------------
// m3h_front
// Input side: takes blocks, clamps the byte count, sorts each block into a
// body round or a tail, masks unused bytes and pushes it to the queue.
// ----------------------------------------------------------------------------
module m3h_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       in_word_low,
  input  logic [63:0]       in_word_high,
  input  logic [4:0]        in_byte_count,
  input  logic              in_last,
  input  logic              q_full,
  output logic              q_push,
  output m3h_pkg::blk_t     q_data
);

  logic [4:0] n_clamp;
  logic       is_body;

  always_comb begin
    n_clamp = (in_byte_count > m3h_pkg::BLOCK_BYTES) ? m3h_pkg::BLOCK_BYTES : in_byte_count;
    is_body = !in_last || (n_clamp == m3h_pkg::BLOCK_BYTES);
    q_data.cnt  = is_body ? m3h_pkg::BLOCK_BYTES : n_clamp;
    q_data.last = in_last;
    q_data.body = is_body;
    q_data.w0   = m3h_pkg::keep_bytes(in_word_low, q_data.cnt, 5'd0);
    q_data.w1   = m3h_pkg::keep_bytes(in_word_high, q_data.cnt, 5'd8);
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

>>> src/m3h_queue.sv
// ----------------------------------------------------------------------------
// m3h_queue
// Short queue of classified blocks between the front and the back end.
// ----------------------------------------------------------------------------
module m3h_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  m3h_pkg::blk_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output m3h_pkg::blk_t head
);

  m3h_pkg::blk_t                  ent_r [m3h_pkg::QDEPTH];
  logic [m3h_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [m3h_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;

  function automatic logic [m3h_pkg::QPTR_W-1:0] ptr_inc(input logic [m3h_pkg::QPTR_W-1:0] p);
    return (p == m3h_pkg::QPTR_W'(m3h_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (cnt_r == m3h_pkg::QCNT_W'(m3h_pkg::QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/m3h_mul.sv
// ----------------------------------------------------------------------------
// m3h_mul
// Low 64 bits of a 64 by 64 product, built from three 32 by 32 partial
// products on one shared multiplier.
// ----------------------------------------------------------------------------
module m3h_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);

  logic [63:0] a_r, b_r;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [1:0]  step_r;
  logic        run_r;
  logic        done_r;
  logic [31:0] op_a, op_b;

  always_comb begin
    case (step_r)
      2'd0: begin
        op_a = a_r[31:0];
        op_b = b_r[31:0];
      end
      2'd1: begin
        op_a = a_r[31:0];
        op_b = b_r[63:32];
      end
      default: begin
        op_a = a_r[63:32];
        op_b = b_r[31:0];
      end
    endcase
    prod_nxt = {32'd0, op_a} * {32'd0, op_b};
    if (step_r == 2'd1) begin
      acc_nxt = prod_r;
    end else begin
      acc_nxt = acc_r + {prod_r[31:0], 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == 2'd3) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (run_r) begin
      prod_r <= prod_nxt;
      acc_r  <= acc_nxt;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

>>> src/m3h_back.sv
// ----------------------------------------------------------------------------
// m3h_back
// Back end: sequencer that scrambles block words, updates both lanes,
// folds in the length, runs the finaliser and registers the hash.
// ----------------------------------------------------------------------------
module m3h_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_nonempty,
  input  m3h_pkg::blk_t q_head,
  output logic          q_pop,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [63:0]   out_digest_hi,
  output logic [63:0]   out_digest_lo
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_K1A   = 16'h0002,
    S_K1B   = 16'h0004,
    S_K2A   = 16'h0008,
    S_K2B   = 16'h0010,
    S_MIX1  = 16'h0020,
    S_MIX2  = 16'h0040,
    S_TAIL  = 16'h0080,
    S_FIN0  = 16'h0100,
    S_FIN1  = 16'h0200,
    S_F1A   = 16'h0400,
    S_F1B   = 16'h0800,
    S_F2A   = 16'h1000,
    S_F2B   = 16'h2000,
    S_FOUT1 = 16'h4000,
    S_FOUT2 = 16'h8000
  } state_t;

  state_t        state_r, state_nxt;
  m3h_pkg::blk_t ent_r, ent_nxt;
  logic [63:0]   h1_r, h1_nxt, h2_r, h2_nxt, tot_r, tot_nxt;
  logic [63:0]   k1_r, k1_nxt, k2_r, k2_nxt;
  logic [31:0]   seed_r;
  logic          busy_r, busy_nxt;
  logic          ov_r, ov_nxt;
  logic [63:0]   oh_r, oh_nxt, ol_r, ol_nxt;
  logic          m_start, m_done;
  logic [63:0]   m_a, m_b, m_p;
  logic [63:0]   t;

  m3h_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (m_start),
    .a     (m_a),
    .b     (m_b),
    .done  (m_done),
    .p     (m_p)
  );

  always_comb begin
    state_nxt = state_r;
    ent_nxt   = ent_r;
    h1_nxt    = h1_r;
    h2_nxt    = h2_r;
    tot_nxt   = tot_r;
    k1_nxt    = k1_r;
    k2_nxt    = k2_r;
    busy_nxt  = busy_r;
    ov_nxt    = ov_r && !out_ready;
    oh_nxt    = oh_r;
    ol_nxt    = ol_r;
    q_pop     = 1'b0;
    m_start   = 1'b0;
    m_a       = q_head.w0;
    m_b       = m3h_pkg::MUL_K1;
    t         = '0;
    case (state_r)
      S_IDLE: begin
        if (q_nonempty) begin
          q_pop   = 1'b1;
          ent_nxt = q_head;
          if (!busy_r) begin
            h1_nxt  = {32'd0, seed_r};
            h2_nxt  = {32'd0, seed_r};
            tot_nxt = '0;
          end
          m_start   = 1'b1;
          state_nxt = S_K1A;
        end
      end
      S_K1A: begin
        m_a = m3h_pkg::rotl64(m_p, 31);
        m_b = m3h_pkg::MUL_K2;
        if (m_done) begin
          m_start   = 1'b1;
          state_nxt = S_K1B;
        end
      end
      S_K1B: begin
        m_a = ent_r.w1;
        m_b = m3h_pkg::MUL_K2;
        if (m_done) begin
          k1_nxt    = m_p;
          m_start   = 1'b1;
          state_nxt = S_K2A;
        end
      end
      S_K2A: begin
        m_a = m3h_pkg::rotl64(m_p, 33);
        m_b = m3h_pkg::MUL_K1;
        if (m_done) begin
          m_start   = 1'b1;
          state_nxt = S_K2B;
        end
      end
      S_K2B: begin
        if (m_done) begin
          k2_nxt    = m_p;
          state_nxt = ent_r.body ? S_MIX1 : S_TAIL;
        end
      end
      S_MIX1: begin
        t         = m3h_pkg::rotl64(h1_r ^ k1_r, 27) + h2_r;
        h1_nxt    = (t << 2) + t + m3h_pkg::ADD_H1;
        state_nxt = S_MIX2;
      end
      S_MIX2: begin
        t         = m3h_pkg::rotl64(h2_r ^ k2_r, 31) + h1_r;
        h2_nxt    = (t << 2) + t + m3h_pkg::ADD_H2;
        tot_nxt   = tot_r + {59'd0, ent_r.cnt};
        busy_nxt  = 1'b1;
        state_nxt = ent_r.last ? S_FIN0 : S_IDLE;
      end
      S_TAIL: begin
        h1_nxt    = h1_r ^ k1_r;
        h2_nxt    = h2_r ^ k2_r;
        tot_nxt   = tot_r + {59'd0, ent_r.cnt};
        state_nxt = S_FIN0;
      end
      S_FIN0: begin
        h1_nxt    = (h1_r ^ tot_r) + (h2_r ^ tot_r);
        h2_nxt    = h2_r ^ tot_r;
        state_nxt = S_FIN1;
      end
      S_FIN1: begin
        h2_nxt    = h2_r + h1_r;
        m_a       = m3h_pkg::xshift33(h1_r);
        m_b       = m3h_pkg::FMIX_C1;
        m_start   = 1'b1;
        state_nxt = S_F1A;
      end
      S_F1A: begin
        m_a = m3h_pkg::xshift33(m_p);
        m_b = m3h_pkg::FMIX_C2;
        if (m_done) begin
          m_start   = 1'b1;
          state_nxt = S_F1B;
        end
      end
      S_F1B: begin
        m_a = m3h_pkg::xshift33(h2_r);
        m_b = m3h_pkg::FMIX_C1;
        if (m_done) begin
          h1_nxt    = m3h_pkg::xshift33(m_p);
          m_start   = 1'b1;
          state_nxt = S_F2A;
        end
      end
      S_F2A: begin
        m_a = m3h_pkg::xshift33(m_p);
        m_b = m3h_pkg::FMIX_C2;
        if (m_done) begin
          m_start   = 1'b1;
          state_nxt = S_F2B;
        end
      end
      S_F2B: begin
        if (m_done) begin
          h2_nxt    = m3h_pkg::xshift33(m_p);
          state_nxt = S_FOUT1;
        end
      end
      S_FOUT1: begin
        h1_nxt    = h1_r + h2_r;
        state_nxt = S_FOUT2;
      end
      S_FOUT2: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          ol_nxt    = h1_r;
          oh_nxt    = h2_r + h1_r;
          busy_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      ov_r    <= 1'b0;
      seed_r  <= '0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid) begin
        seed_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    h1_r  <= h1_nxt;
    h2_r  <= h2_nxt;
    tot_r <= tot_nxt;
    k1_r  <= k1_nxt;
    k2_r  <= k2_nxt;
    oh_r  <= oh_nxt;
    ol_r  <= ol_nxt;
  end

  assign cfg_ready     = 1'b1;
  assign out_valid     = ov_r;
  assign out_digest_hi = oh_r;
  assign out_digest_lo = ol_r;

endmodule

>>> src/murmur3_128_hash_stream.sv
// ----------------------------------------------------------------------------
// murmur3_128_hash_stream
// 128-bit murmur hash (x64 variant) of a message streamed as 16-byte blocks.
// ----------------------------------------------------------------------------
// Feed each message as 16-byte blocks, bytes 0..7 on in_word_low and 8..15
// on in_word_high, both little-endian; mark the final block with in_last and
// give its valid byte count (0 to 16, larger counts taken as 16). One hash
// item comes out per message. The seed written on the cfg port is used from
// the next message on. Every 64-bit product is built on one shared 32 by 32
// multiplier (three partial products), and each block needs four products in
// series; the final block also runs the finaliser. A queue of two blocks
// lets input be taken while the back end works and while a finished hash
// waits.
// ----------------------------------------------------------------------------
module murmur3_128_hash_stream (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_word_low,
  input  logic [63:0] in_word_high,
  input  logic [4:0]  in_byte_count,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_hi,
  output logic [63:0] out_digest_lo,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  m3h_pkg::blk_t push_data, head;
  logic          push, full, pop, nonempty;

  m3h_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_word_low   (in_word_low),
    .in_word_high  (in_word_high),
    .in_byte_count (in_byte_count),
    .in_last       (in_last),
    .q_full        (full),
    .q_push        (push),
    .q_data        (push_data)
  );

  m3h_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .nonempty  (nonempty),
    .head      (head)
  );

  m3h_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_nonempty    (nonempty),
    .q_head        (head),
    .q_pop         (pop),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_digest_hi (out_digest_hi),
    .out_digest_lo (out_digest_lo)
  );

endmodule

>>> src/m3h_checker.sv
// ----------------------------------------------------------------------------
// m3h_checker
// Port-level checks: hashes only follow final blocks, the number in flight
// stays bounded, and a stalled hash item holds.
// ----------------------------------------------------------------------------
module m3h_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_digest_hi,
  input logic [63:0] out_digest_lo
);

  logic [2:0] pend_r;
  logic       inc, dec;

  assign inc = in_valid && in_ready && in_last;
  assign dec = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (inc && !dec) begin
      pend_r <= pend_r + 1'b1;
    end else if (dec && !inc) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  a_out_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 3'd0))
    else $error("hash item without a pending final block");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd4)
    else $error("too many messages in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_digest_hi) && $stable(out_digest_lo)))
    else $error("stalled hash item changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("hash item right after reset");

endmodule

bind murmur3_128_hash_stream m3h_checker u_chk (.*);

>>> tb/m3h_hash_checker.sv
// ----------------------------------------------------------------------------
// m3h_hash_checker
// Watches the block, cfg and hash channels of the murmur hash stream, keeps
// its own copy of the seed, lanes and message length, works out the 128-bit
// hash due for every final block and compares each accepted hash item with
// the oldest one due. Hands the mismatch count and the number of hashes
// still outstanding to the testbench top.
// ----------------------------------------------------------------------------
module m3h_hash_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] in_word_low,
  input  logic [63:0] in_word_high,
  input  logic [4:0]  in_byte_count,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_digest_hi,
  input  logic [63:0] out_digest_lo,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int unsigned mismatches,
  output int unsigned hashes_due
);

  localparam logic [63:0] K1 = 64'h87c37b91114253d5;
  localparam logic [63:0] K2 = 64'h4cf5ad432745937f;
  localparam logic [63:0] FMIX_A = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_B = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] LANE_A_ADD = 64'h52dce729;
  localparam logic [63:0] LANE_B_ADD = 64'h38495ab5;

  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
  } digest_t;

  digest_t     digest_q[$];
  logic [31:0] seed_reg;
  logic [63:0] lane_a;
  logic [63:0] lane_b;
  logic [63:0] msg_len;
  bit          in_msg;

  function automatic logic [63:0] rot_left(input logic [63:0] v, input int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

  function automatic logic [63:0] final_mix(input logic [63:0] v);
    logic [63:0] x;
    x = v ^ (v >> 33);
    x = x * FMIX_A;
    x = x ^ (x >> 33);
    x = x * FMIX_B;
    return x ^ (x >> 33);
  endfunction

  function automatic logic [63:0] mix_k1(input logic [63:0] k);
    return rot_left(k * K1, 31) * K2;
  endfunction

  function automatic logic [63:0] mix_k2(input logic [63:0] k);
    return rot_left(k * K2, 33) * K1;
  endfunction

  function automatic logic [63:0] low_bytes(input logic [63:0] v, input int unsigned n);
    if (n >= 8) return v;
    if (n == 0) return 64'd0;
    return v & ((64'd1 << (8 * n)) - 64'd1);
  endfunction

  task automatic mix_body(input logic [63:0] w0, input logic [63:0] w1);
    lane_a = rot_left(lane_a ^ mix_k1(w0), 27) + lane_b;
    lane_a = lane_a * 64'd5 + LANE_A_ADD;
    lane_b = rot_left(lane_b ^ mix_k2(w1), 31) + lane_a;
    lane_b = lane_b * 64'd5 + LANE_B_ADD;
  endtask

  task automatic absorb_block(input logic [63:0] w0, input logic [63:0] w1,
                              input logic [4:0] cnt, input logic last);
    int unsigned n;
    logic [63:0] h1;
    logic [63:0] h2;
    if (!in_msg) begin
      lane_a = {32'd0, seed_reg};
      lane_b = {32'd0, seed_reg};
      msg_len = '0;
      in_msg = 1'b1;
    end
    if (!last) begin
      mix_body(w0, w1);
      msg_len += 64'd16;
    end else begin
      n = (cnt > 5'd16) ? 16 : int'(cnt);
      if (n == 16) begin
        mix_body(w0, w1);
      end else begin
        if (n > 8) lane_b ^= mix_k2(low_bytes(w1, n - 8));
        if (n > 0) lane_a ^= mix_k1(low_bytes(w0, n));
      end
      msg_len += 64'(n);
      h1 = lane_a ^ msg_len;
      h2 = lane_b ^ msg_len;
      h1 += h2;
      h2 += h1;
      h1 = final_mix(h1);
      h2 = final_mix(h2);
      h1 += h2;
      h2 += h1;
      digest_q.push_back('{high: h2, low: h1});
      in_msg = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    digest_t want;
    if (!rst_n) begin
      seed_reg = '0;
      lane_a = '0;
      lane_b = '0;
      msg_len = '0;
      in_msg = 1'b0;
      mismatches = 0;
      digest_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t unexpected hash item high %h low %h", $time,
                   out_digest_hi, out_digest_lo);
          mismatches++;
        end else begin
          want = digest_q.pop_front();
          if (out_digest_hi !== want.high) begin
            $display("%0t digest_hi expected %h actual %h", $time, want.high,
                     out_digest_hi);
            mismatches++;
          end
          if (out_digest_lo !== want.low) begin
            $display("%0t digest_lo expected %h actual %h", $time, want.low,
                     out_digest_lo);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        seed_reg = cfg_data;
      end
      if (in_valid && in_ready) begin
        absorb_block(in_word_low, in_word_high, in_byte_count, in_last);
      end
    end
    hashes_due = digest_q.size();
  end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the murmur hash stream with a directed set of blocks covering an
// empty message, every tail shape, oversized counts and multi-block messages,
// then random messages under several seeds and idling patterns, including a
// long output hold-off that backs the block up. The checker beside the block
// predicts and compares every hash item; this module only makes stimulus and
// gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_word_low;
  logic [63:0] in_word_high;
  logic [4:0]  in_byte_count;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_digest_hi;
  logic [63:0] out_digest_lo;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  int unsigned mismatches;
  int unsigned hashes_due;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned items_sent;
  bit          hold_req;
  bit          hold_done;

  localparam int unsigned HOLD_CYCLES = 500;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned PHASE_ITEMS = 300;

  murmur3_128_hash_stream i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_word_low  (in_word_low),
    .in_word_high (in_word_high),
    .in_byte_count(in_byte_count),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_digest_hi(out_digest_hi),
    .out_digest_lo(out_digest_lo),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  m3h_hash_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_word_low  (in_word_low),
    .in_word_high (in_word_high),
    .in_byte_count(in_byte_count),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_digest_hi(out_digest_hi),
    .out_digest_lo(out_digest_lo),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .hashes_due   (hashes_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

  // hash receiver, with one long hold-off on request
  initial begin
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [63:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(15);
    if (pick == 0) return 64'd0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic send_block(input logic [63:0] w0, input logic [63:0] w1,
                            input logic [4:0] cnt, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word_low <= w0;
    in_word_high <= w1;
    in_byte_count <= cnt;
    in_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random_message(input int unsigned max_blocks);
    int unsigned blocks;
    int unsigned pick;
    int unsigned b;
    logic [4:0] tail;
    pick = $urandom_range(99);
    if (pick < 70) blocks = $urandom_range(4, 1);
    else if (pick < 95) blocks = $urandom_range(12, 5);
    else blocks = $urandom_range(40, 13);
    if (blocks > max_blocks) blocks = max_blocks;
    for (b = 1; b < blocks; b++) begin
      send_block(rand_word(), rand_word(), 5'($urandom_range(31)), 1'b0);
    end
    tail = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 17)) : 5'($urandom_range(16));
    send_block(rand_word(), rand_word(), tail, 1'b1);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (hashes_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] seeds[4];
    int unsigned idles[4];
    int unsigned stalls[4];
    int unsigned phase_end;
    int unsigned p;
    seeds = '{32'hffffffff, $urandom, 32'h00000000, $urandom};
    idles = '{0, 79, 0, 19};
    stalls = '{0, 0, 79, 19};
    idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_word_low <= '0;
    in_word_high <= '0;
    in_byte_count <= '0;
    in_last <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty message, every tail shape, oversized counts
    send_block('1, '1, 5'd0, 1'b1);
    send_block('1, '1, 5'd1, 1'b1);
    send_block('1, '1, 5'd7, 1'b1);
    send_block(rand_word(), rand_word(), 5'd8, 1'b1);
    send_block('1, '1, 5'd9, 1'b1);
    send_block(rand_word(), '1, 5'd15, 1'b1);
    send_block(rand_word(), rand_word(), 5'd16, 1'b1);
    send_block(rand_word(), rand_word(), 5'd17, 1'b1);
    send_block('1, '1, 5'd31, 1'b1);
    send_block('0, '0, 5'd16, 1'b1);
    send_block('1, '1, 5'd16, 1'b1);
    // multi-block messages, count on non-final items ignored
    send_block(rand_word(), rand_word(), 5'd0, 1'b0);
    send_block(rand_word(), rand_word(), 5'd16, 1'b1);
    send_block('1, '1, 5'd31, 1'b0);
    send_block(rand_word(), rand_word(), 5'd5, 1'b0);
    send_block('1, '1, 5'd0, 1'b1);
    send_block('0, '0, 5'd3, 1'b0);
    send_block(rand_word(), rand_word(), 5'd12, 1'b1);

    for (p = 0; p < 4; p++) begin
      settle();
      write_seed(seeds[p]);
      idle_pct = idles[p];
      stall_pct = stalls[p];
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_random_message(40);
    end

    // long output hold-off while short messages keep coming
    settle();
    write_seed(32'h80000000);
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    repeat (16) send_random_message(1);
    repeat (10) send_random_message(40);

    settle();
    if (mismatches == 0 && hashes_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
